### design/hpmc_pkg.sv
`default_nettype none

package hpmc_pkg;

    localparam int PIX_W          = 8;
    localparam int MAX_BLOCK_W    = 16;
    localparam int MAX_BLOCK_H    = 16;
    localparam int NARROW_W       = 8;
    localparam int STORE_DEPTH    = MAX_BLOCK_W + 1;
    localparam int TAP_W          = $clog2(STORE_DEPTH);
    localparam int CNT_W          = 5;
    localparam int PITCH_W        = 12;
    localparam int OFFSET_W       = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 12;
    localparam int HEIGHT_W       = 5;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_BLOCK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_X       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_Y       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH    = 3'd5;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] dest_offset;
        pix_t                pred_pixel;
        logic                last;
    } res_t;

    // Copy, two-tap or four-tap rounded mean, then the optional average
    // with the destination pixel.
    function automatic pix_t interp(
        input pix_t left_above,
        input pix_t above,
        input pix_t left,
        input pix_t now,
        input pix_t cur,
        input logic hx,
        input logic hy,
        input logic avg
    );
        logic [PIX_W+1:0] sum;
        pix_t             p;
        logic [PIX_W:0]   avg_sum;
        begin
            sum = '0;
            if (hx && hy) begin
                sum = {2'b00, left_above} + {2'b00, above} + {2'b00, left}
                      + {2'b00, now} + 10'd2;
                p = sum[PIX_W+1:2];
            end else if (hx) begin
                sum = {2'b00, left} + {2'b00, now} + 10'd1;
                p = sum[PIX_W:1];
            end else if (hy) begin
                sum = {2'b00, above} + {2'b00, now} + 10'd1;
                p = sum[PIX_W:1];
            end else begin
                p = now;
            end
            avg_sum = {1'b0, p} + {1'b0, cur} + 9'd1;
            if (avg) begin
                p = avg_sum[PIX_W:1];
            end
            return p;
        end
    endfunction

endpackage

`default_nettype wire

### design/half_pel_motion_compensation.sv
`default_nettype none

// Results are registered in the output register, or in the skid entry on a stall.
// Throughput: one reference pixel per cycle while s_tready is high; the line of pixel cells and the
// arithmetic take a new pixel every cycle, and a two-entry output stage absorbs stalls.
// Reset (aresetn low, synchronous): registers return to their default values,
// the window position and neighbor pixels clear, and the output stage empties.
module half_pel_motion_compensation
    import hpmc_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire  [15:0]             s_tdata,   // [7:0] ref_pixel, [15:8] cur_pixel
    output logic                    m_tvalid,
    input  wire                     m_tready,
    output logic [23:0]             m_tdata,   // [7:0] pred_pixel, [23:8] dest_offset
    output logic                    m_tlast,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire  [CFG_IDX_W-1:0]    cfg_index,
    input  wire  [CFG_DATA_W-1:0]   cfg_data
);

    logic                wide_block_reg;
    logic                half_x_reg;
    logic                half_y_reg;
    logic                average_mode_reg;
    logic [HEIGHT_W-1:0] block_height_reg;
    logic [PITCH_W-1:0]  row_pitch_reg;

    logic [CNT_W-1:0]    col_reg, col_next;
    logic [CNT_W-1:0]    row_reg, row_next;
    pix_t                left_reg, left_next;
    pix_t                left_above_reg, left_above_next;

    logic                out_valid_reg, out_valid_next;
    res_t                out_data_reg, out_data_next;
    logic                skid_valid_reg, skid_valid_next;
    res_t                skid_data_reg, skid_data_next;

    logic                cfg_write;
    logic                cfg_hit;
    logic                accept;
    logic                pop;
    pix_t                ref_pixel;
    pix_t                cur_pixel;
    pix_t                above;
    logic [CNT_W-1:0]    cols_w;
    logic [CNT_W-1:0]    rows_w;
    logic [CNT_W-1:0]    eff_height;
    logic                col_end;
    logic                final_pixel;
    logic                emit;
    logic [CNT_W-1:0]    x_pos;
    logic [CNT_W-1:0]    y_pos;
    logic [16:0]         offset_full;
    res_t                new_res;

    assign ref_pixel = s_tdata[7:0];
    assign cur_pixel = s_tdata[15:8];

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_write && (cfg_index == REG_WIDE_BLOCK
                                     || cfg_index == REG_HALF_X
                                     || cfg_index == REG_HALF_Y
                                     || cfg_index == REG_AVERAGE_MODE
                                     || cfg_index == REG_BLOCK_HEIGHT
                                     || cfg_index == REG_ROW_PITCH);

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    always_comb begin
        if (block_height_reg == '0) begin
            eff_height = CNT_W'(1);
        end else if (block_height_reg inside {[MAX_BLOCK_H+1:31]}) begin
            eff_height = CNT_W'(MAX_BLOCK_H);
        end else begin
            eff_height = block_height_reg;
        end
    end

    assign cols_w = (wide_block_reg ? CNT_W'(MAX_BLOCK_W) : CNT_W'(NARROW_W))
                    + CNT_W'(half_x_reg);
    assign rows_w = eff_height + CNT_W'(half_y_reg);

    assign col_end     = (col_reg + CNT_W'(1)) >= cols_w;
    assign final_pixel = col_end && ((row_reg + CNT_W'(1)) >= rows_w);
    assign emit        = (col_reg >= CNT_W'(half_x_reg)) && (row_reg >= CNT_W'(half_y_reg));

    hpmc_line_chain u_line (
        .aclk    (aclk),
        .shift_en(accept),
        .pix_in  (ref_pixel),
        .tap_sel (TAP_W'(cols_w - CNT_W'(1))),
        .tap_out (above)
    );

    assign x_pos       = col_reg - CNT_W'(half_x_reg);
    assign y_pos       = row_reg - CNT_W'(half_y_reg);
    assign offset_full = 17'(y_pos) * 17'(row_pitch_reg) + 17'(x_pos);

    always_comb begin
        new_res.pred_pixel  = interp(left_above_reg, above, left_reg, ref_pixel, cur_pixel,
                                     half_x_reg, half_y_reg, average_mode_reg);
        new_res.dest_offset = offset_full[OFFSET_W-1:0];
        new_res.last        = final_pixel;
    end

    // Window position and neighbor pixels.
    always_comb begin
        col_next        = col_reg;
        row_next        = row_reg;
        left_next       = left_reg;
        left_above_next = left_above_reg;
        if (cfg_hit) begin
            col_next        = '0;
            row_next        = '0;
            left_next       = '0;
            left_above_next = '0;
        end else if (accept) begin
            left_next       = ref_pixel;
            left_above_next = above;
            if (final_pixel) begin
                col_next        = '0;
                row_next        = '0;
                left_next       = '0;
                left_above_next = '0;
            end else if (col_end) begin
                col_next = '0;
                row_next = row_reg + CNT_W'(1);
            end else begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    // Output register with a skid entry behind it.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (accept && emit) begin
            if (!out_valid_reg || pop) begin
                out_valid_next = 1'b1;
                out_data_next  = new_res;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = new_res;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_block_reg   <= 1'b1;
            half_x_reg       <= 1'b0;
            half_y_reg       <= 1'b0;
            average_mode_reg <= 1'b0;
            block_height_reg <= HEIGHT_W'(MAX_BLOCK_H);
            row_pitch_reg    <= PITCH_W'(16);
        end else if (cfg_write) begin
            case (cfg_index)
                REG_WIDE_BLOCK:   wide_block_reg   <= cfg_data[0];
                REG_HALF_X:       half_x_reg       <= cfg_data[0];
                REG_HALF_Y:       half_y_reg       <= cfg_data[0];
                REG_AVERAGE_MODE: average_mode_reg <= cfg_data[0];
                REG_BLOCK_HEIGHT: block_height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_ROW_PITCH:    row_pitch_reg    <= cfg_data[PITCH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            left_reg       <= '0;
            left_above_reg <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            left_reg       <= left_next;
            left_above_reg <= left_above_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.dest_offset, out_data_reg.pred_pixel};
    assign m_tlast  = out_data_reg.last;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    a_col_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg < cols_w)
        else $error("column position ran past the window width");

    a_row_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg < rows_w)
        else $error("row position ran past the window height");

    a_block_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && final_pixel && !cfg_hit) |=> (col_reg == '0 && row_reg == '0))
        else $error("window position did not return to the origin after the block");

endmodule

`default_nettype wire

### design/hpmc_cell.sv
`default_nettype none

module hpmc_cell
    import hpmc_pkg::*;
(
    input  wire  aclk,
    input  wire  shift_en,
    input  pix_t pix_in,
    output pix_t pix_out
);

    pix_t pix_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            pix_reg <= pix_in;
        end
    end

    assign pix_out = pix_reg;

endmodule

`default_nettype wire

### design/hpmc_line_chain.sv
`default_nettype none

module hpmc_line_chain
    import hpmc_pkg::*;
(
    input  wire              aclk,
    input  wire              shift_en,
    input  pix_t             pix_in,
    input  logic [TAP_W-1:0] tap_sel,
    output pix_t             tap_out
);

    pix_t cell_q [STORE_DEPTH];

    // Cell k holds the pixel taken k+1 requests ago, so the pixel one
    // window row above the incoming one sits in the cell at (columns - 1).
    for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            hpmc_cell u_cell (
                .aclk    (aclk),
                .shift_en(shift_en),
                .pix_in  (pix_in),
                .pix_out (cell_q[i])
            );
        end else begin : g_body
            hpmc_cell u_cell (
                .aclk    (aclk),
                .shift_en(shift_en),
                .pix_in  (cell_q[i-1]),
                .pix_out (cell_q[i])
            );
        end
    end

    assign tap_out = cell_q[tap_sel];

endmodule

`default_nettype wire
